### hw/rtl/hmr_pkg.sv
// shared types and codes for the health monitor with recovery
// no dependencies; imported by hmr_in_if, hmr_core and the top level (hmr_out_if does not use it)
package hmr_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned CfgWidth   = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic [CountWidth-1:0] WarnThresholdReset = 8'd2;
  localparam logic [CountWidth-1:0] FailThresholdReset = 8'd5;
  localparam logic [TimeWidth-1:0]  RecoveryIntervalReset = 32'd10000;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_WARN_THRESHOLD    = 2'd0,
    REG_FAIL_THRESHOLD    = 2'd1,
    REG_RECOVERY_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CODE_OK          = 3'd0,
    CODE_SENSOR_WARN = 3'd1,
    CODE_TX_WARN     = 3'd2,
    CODE_NO_SENSOR   = 3'd3,
    CODE_NO_SERVO    = 3'd4,
    CODE_SENSOR_FAIL = 3'd5,
    CODE_TX_FAIL     = 3'd6,
    CODE_BUS_FAULT   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    COLOR_GREEN  = 2'd0,
    COLOR_YELLOW = 2'd1,
    COLOR_RED    = 2'd2
  } color_t;

  typedef struct packed {
    logic                 action;
    logic                 bus_fault;
    logic                 sensor_present;
    logic                 actuator_attached;
    logic                 sensor_ok;
    logic                 tx_ok;
    logic [TimeWidth-1:0] now_ms;
    logic                 sensor_restored;
    logic                 radio_restored;
  } in_item_t;

  typedef struct packed {
    status_t status_code;
    color_t  color;
    logic    code_changed;
    logic    request_bus_recovery;
    logic    request_sensor_retry;
    logic    request_radio_retry;
  } out_item_t;

  function automatic color_t color_of(input status_t code);
    color_t c;
    case (code)
      CODE_OK:                    c = COLOR_GREEN;
      CODE_SENSOR_WARN,
      CODE_TX_WARN:               c = COLOR_YELLOW;
      default:                    c = COLOR_RED;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/hmr_in_if.sv
// report channel of the health monitor: valid/ready plus report fields
// depends on hmr_pkg for widths
interface hmr_in_if;
  import hmr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic                 bus_fault;
  logic                 sensor_present;
  logic                 actuator_attached;
  logic                 sensor_ok;
  logic                 tx_ok;
  logic [TimeWidth-1:0] now_ms;
  logic                 sensor_restored;
  logic                 radio_restored;

  modport source (
    output valid, action, bus_fault, sensor_present, actuator_attached,
           sensor_ok, tx_ok, now_ms, sensor_restored, radio_restored,
    input  ready
  );

  modport sink (
    input  valid, action, bus_fault, sensor_present, actuator_attached,
           sensor_ok, tx_ok, now_ms, sensor_restored, radio_restored,
    output ready
  );
endinterface

### hw/rtl/hmr_out_if.sv
// status channel of the health monitor: valid/ready plus status fields
// no package dependency
interface hmr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status_code;
  logic [1:0] color;
  logic       code_changed;
  logic       request_bus_recovery;
  logic       request_sensor_retry;
  logic       request_radio_retry;

  modport source (
    output valid, status_code, color, code_changed, request_bus_recovery,
           request_sensor_retry, request_radio_retry,
    input  ready
  );

  modport sink (
    input  valid, status_code, color, code_changed, request_bus_recovery,
           request_sensor_retry, request_radio_retry,
    output ready
  );
endinterface

### hw/rtl/health_monitor_with_recovery.sv
// top level of the health monitor with recovery: input stage, evaluation, output stage
// depends on hmr_pkg, hmr_in_if, hmr_out_if and hmr_core
//
//   channel  | direction | transaction
//   in_ch    | in        | one report: periodic outcome or recovery result
//   out_ch   | out       | one status: code, color, change flag, retry requests
//   cfg_*    | in        | register write, index 0..2, no read-back
//
// one report per cycle unless out_ch stalls; the status is registered after stage s1
// reports are evaluated one after another against the health state, no gaps needed
// rst is synchronous; it empties both stages and restores thresholds and state
// a stalled out_ch holds its status; in_ch stays ready while the output stage can drain
module health_monitor_with_recovery (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hmr_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [hmr_pkg::CfgWidth-1:0]    cfg_data,
  hmr_in_if.sink                          in_ch,
  hmr_out_if.source                       out_ch
);
  import hmr_pkg::*;

  in_item_t  s1_item;
  logic      s1_valid;
  out_item_t res;
  out_item_t out_item;
  logic      out_valid;
  logic      advance;
  in_item_t  in_item;

  assign advance = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  always_comb begin
    in_item.action            = in_ch.action;
    in_item.bus_fault         = in_ch.bus_fault;
    in_item.sensor_present    = in_ch.sensor_present;
    in_item.actuator_attached = in_ch.actuator_attached;
    in_item.sensor_ok         = in_ch.sensor_ok;
    in_item.tx_ok             = in_ch.tx_ok;
    in_item.now_ms            = in_ch.now_ms;
    in_item.sensor_restored   = in_ch.sensor_restored;
    in_item.radio_restored    = in_ch.radio_restored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item <= in_item;
    end
  end

  hmr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .en        (s1_valid && advance),
    .item      (s1_item),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_item <= res;
    end
  end

  assign out_ch.valid                = out_valid;
  assign out_ch.status_code          = out_item.status_code;
  assign out_ch.color                = out_item.color;
  assign out_ch.code_changed         = out_item.code_changed;
  assign out_ch.request_bus_recovery = out_item.request_bus_recovery;
  assign out_ch.request_sensor_retry = out_item.request_sensor_retry;
  assign out_ch.request_radio_retry  = out_item.request_radio_retry;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> s1_valid && out_valid && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  a_request_needs_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.request_bus_recovery || out_item.request_sensor_retry ||
                  out_item.request_radio_retry) |-> out_item.color == COLOR_RED)
    else $error("retry request without red status");

  a_bus_request_pairs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.request_bus_recovery |-> out_item.request_sensor_retry)
    else $error("bus recovery without sensor retry");

endmodule

### hw/rtl/hmr_core.sv
// health state, thresholds and status evaluation for one report per cycle while en is high
// depends on hmr_pkg
module hmr_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hmr_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [hmr_pkg::CfgWidth-1:0]         cfg_data,
  input  logic                                 en,
  input  hmr_pkg::in_item_t                    item,
  output hmr_pkg::out_item_t                   res
);
  import hmr_pkg::*;

  logic [CountWidth-1:0] warn_threshold;
  logic [CountWidth-1:0] fail_threshold;
  logic [TimeWidth-1:0]  recovery_period;

  logic [CountWidth-1:0] sensor_fail_count, sensor_fail_count_next;
  logic [CountWidth-1:0] tx_fail_count, tx_fail_count_next;
  status_t               current_code, current_code_next;
  logic [TimeWidth-1:0]  last_recovery_ms, last_recovery_ms_next;

  logic                  all_present;
  logic [CountWidth-1:0] s_cnt, t_cnt;
  status_t               code;
  color_t                color;
  logic [TimeWidth-1:0]  elapsed;
  logic                  fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_threshold  <= WarnThresholdReset;
      fail_threshold  <= FailThresholdReset;
      recovery_period <= RecoveryIntervalReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WARN_THRESHOLD:    warn_threshold <= cfg_data[CountWidth-1:0];
        REG_FAIL_THRESHOLD:    fail_threshold <= cfg_data[CountWidth-1:0];
        REG_RECOVERY_INTERVAL: recovery_period <= cfg_data[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    all_present = !item.bus_fault && item.sensor_present && item.actuator_attached;

    // saturating consecutive-failure counters
    s_cnt = item.sensor_ok ? '0 :
            (sensor_fail_count == CountMax) ? CountMax :
            sensor_fail_count + CountWidth'(1);
    t_cnt = item.tx_ok ? '0 :
            (tx_fail_count == CountMax) ? CountMax : tx_fail_count + CountWidth'(1);

    if (item.bus_fault)                code = CODE_BUS_FAULT;
    else if (!item.sensor_present)     code = CODE_NO_SENSOR;
    else if (!item.actuator_attached)  code = CODE_NO_SERVO;
    else if (s_cnt >= fail_threshold)  code = CODE_SENSOR_FAIL;
    else if (t_cnt >= fail_threshold)  code = CODE_TX_FAIL;
    else if (s_cnt >= warn_threshold)  code = CODE_SENSOR_WARN;
    else if (t_cnt >= warn_threshold)  code = CODE_TX_WARN;
    else                               code = CODE_OK;

    color   = color_of(code);
    elapsed = item.now_ms - last_recovery_ms;
    fire    = (color == COLOR_RED) && (elapsed >= recovery_period);

    sensor_fail_count_next = sensor_fail_count;
    tx_fail_count_next     = tx_fail_count;
    current_code_next      = current_code;
    last_recovery_ms_next  = last_recovery_ms;

    if (item.action) begin
      if (item.sensor_restored) sensor_fail_count_next = '0;
      if (item.radio_restored)  tx_fail_count_next = '0;
      res.status_code          = current_code;
      res.color                = color_of(current_code);
      res.code_changed         = 1'b0;
      res.request_bus_recovery = 1'b0;
      res.request_sensor_retry = 1'b0;
      res.request_radio_retry  = 1'b0;
    end else begin
      if (all_present) begin
        sensor_fail_count_next = s_cnt;
        tx_fail_count_next     = t_cnt;
      end
      current_code_next = code;
      if (fire) last_recovery_ms_next = item.now_ms;
      res.status_code          = code;
      res.color                = color;
      res.code_changed         = (code != current_code);
      res.request_bus_recovery = fire && (code == CODE_BUS_FAULT);
      res.request_sensor_retry = fire && ((code == CODE_BUS_FAULT) ||
                                          (code == CODE_SENSOR_FAIL) ||
                                          (code == CODE_NO_SENSOR));
      res.request_radio_retry  = fire && (code == CODE_TX_FAIL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_fail_count <= '0;
      tx_fail_count     <= '0;
      current_code      <= CODE_OK;
      last_recovery_ms  <= '0;
    end else if (en) begin
      sensor_fail_count <= sensor_fail_count_next;
      tx_fail_count     <= tx_fail_count_next;
      current_code      <= current_code_next;
      last_recovery_ms  <= last_recovery_ms_next;
    end
  end

  a_recovery_stamp: assert property (@(posedge clk) disable iff (rst)
    en && !item.action && fire |=> last_recovery_ms == $past(item.now_ms))
    else $error("recovery timestamp not taken");

  a_sensor_saturate: assert property (@(posedge clk) disable iff (rst)
    en && !item.action && all_present && !item.sensor_ok &&
    sensor_fail_count == CountMax |=> sensor_fail_count == CountMax)
    else $error("sensor failure count wrapped");

  a_tx_saturate: assert property (@(posedge clk) disable iff (rst)
    en && !item.action && all_present && !item.tx_ok &&
    tx_fail_count == CountMax |=> tx_fail_count == CountMax)
    else $error("tx failure count wrapped");

  a_retry_report_holds_code: assert property (@(posedge clk) disable iff (rst)
    en && item.action |=> current_code == $past(current_code))
    else $error("retry report changed the status code");

endmodule
